/* hw/rtl/assert_macros.svh */
// assert_macros.svh: assertion macros shared by the checker files.
// Depends on nothing; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, masked during reset
`define ESVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esvs check failed");

// Next-cycle implication, sampled on the rising clock, masked during reset
`define ESVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esvs check failed");

`endif

/* hw/rtl/esvs_pkg.sv */
// esvs_pkg: types, field widths, mode codes and saturating add for the
// epoch-scoped variable store. Depends on nothing.
package esvs_pkg;

    localparam int MODE_W     = 2;
    localparam int INDEX_W    = 6;
    localparam int VALUE_W    = 64;
    localparam int DEPTH_W    = 5;
    localparam int EPOCH_IN_W = 16;
    localparam int CFG_W      = 7;

    localparam logic [CFG_W-1:0] SYMBOLS_RESET = 7'd64;

    // Request operation codes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELTA = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ADDV  = 2'd3;

    typedef logic signed [VALUE_W-1:0] value_t;

    localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Signed add clamped to the 64-bit range
    function automatic value_t sat_add(input value_t a, input value_t b);
        value_t s;
        s = a + b;
        if (a[VALUE_W-1] == b[VALUE_W-1] && s[VALUE_W-1] != a[VALUE_W-1]) begin
            s = a[VALUE_W-1] ? VALUE_MIN : VALUE_MAX;
        end
        return s;
    endfunction

endpackage

/* hw/rtl/esvs_ram.sv */
// esvs_ram: single-port-write, single-port-read synchronous memory with a
// registered read. Depends on nothing.
module esvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, data held between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/epoch_scoped_variable_store_top.sv */
// A request is taken in ST_IDLE, where the slot and global memories are read; ST_UPD
// does the read-modify-write of the target entry and loads the result register.
// Add-variable first passes ST_SRC, taking the source lookup as addend while the target
// is read. Index errors load the result at accept and stay in ST_IDLE. A new request
// waits for ST_IDLE and an empty or draining result register. After reset a clearing
// pass over all slots zeroes stamps and global valid bits with s_ready low; configuration writes are taken throughout.
module epoch_scoped_variable_store_top
    import esvs_pkg::*;
#(
    parameter int MAX_SYMBOLS = 64,
    parameter int MAX_FRAMES  = 16,
    parameter int EPOCH_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    // Request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [INDEX_W-1:0]    s_target_index,
    input  logic [INDEX_W-1:0]    s_source_index,
    input  value_t                s_operand_value,
    input  logic [DEPTH_W-1:0]    s_frame_depth,
    input  logic [EPOCH_IN_W-1:0] s_frame_epoch,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output value_t                m_read_value,
    output logic                  m_index_error
);

    localparam int SLOT_COUNT = MAX_FRAMES * MAX_SYMBOLS;
    localparam int SA_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int GA_W   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int SYM_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int CMP_W  = (SYM_W > CFG_W) ? SYM_W : CFG_W;
    localparam int FRM_W  = $clog2(MAX_FRAMES + 1);
    localparam int DEP_W  = (FRM_W > DEPTH_W) ? FRM_W : DEPTH_W;
    localparam int SLOT_W = EPOCH_BITS + VALUE_W;
    localparam int GLB_W  = 1 + VALUE_W;

    // Controller states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SRC   = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [SA_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]      sym_reg;

    // Request held for the memory passes
    logic [MODE_W-1:0]     mode_reg;
    logic                  in_frame_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [SA_W-1:0]       tgt_slot_reg;
    logic [GA_W-1:0]       tgt_glb_reg;
    value_t                addend_reg, addend_next;

    // Result register
    logic                  m_valid_reg, m_valid_next;
    value_t                m_value_reg, m_value_next;
    logic                  m_err_reg, m_err_next;

    // Request decode
    logic                  accept;
    logic                  tgt_ok, src_ok, req_err;
    logic [EPOCH_BITS-1:0] epoch_in;
    logic                  in_frame_in;
    logic [DEP_W-1:0]      depth_x, frame_no;
    logic [SA_W-1:0]       frame_base, tgt_slot_in, src_slot_in;

    // Memory ports
    logic                  slot_we, glb_we, mem_re;
    logic [SA_W-1:0]       slot_waddr, slot_raddr;
    logic [GA_W-1:0]       glb_waddr, glb_raddr;
    logic [SLOT_W-1:0]     slot_wdata, slot_rdata;
    logic [GLB_W-1:0]      glb_wdata, glb_rdata;

    // Lookup and update
    logic [EPOCH_BITS-1:0] rd_stamp;
    value_t                rd_slot_val, rd_glb_val, lookup_val, base_val, result;
    logic                  rd_glb_valid, hit, use_base;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;

    // Index checks, scope and slot addresses from the request ports
    always_comb begin
        tgt_ok = (CMP_W'(s_target_index) < CMP_W'(sym_reg))
              && (CMP_W'(s_target_index) < CMP_W'(MAX_SYMBOLS));
        src_ok = (CMP_W'(s_source_index) < CMP_W'(sym_reg))
              && (CMP_W'(s_source_index) < CMP_W'(MAX_SYMBOLS));
        req_err = !tgt_ok || (s_mode == MODE_ADDV && !src_ok);

        epoch_in    = EPOCH_BITS'(s_frame_epoch);
        in_frame_in = (s_frame_depth != '0) && (epoch_in != '0);

        depth_x  = DEP_W'(s_frame_depth);
        frame_no = (depth_x > DEP_W'(MAX_FRAMES)) ? DEP_W'(MAX_FRAMES - 1)
                                                  : depth_x - DEP_W'(1);
        frame_base  = SA_W'(frame_no * MAX_SYMBOLS);
        tgt_slot_in = frame_base + SA_W'(s_target_index);
        src_slot_in = frame_base + SA_W'(s_source_index);
    end

    // Unpack read data
    always_comb begin
        rd_stamp     = slot_rdata[SLOT_W-1 -: EPOCH_BITS];
        rd_slot_val  = slot_rdata[VALUE_W-1:0];
        rd_glb_valid = glb_rdata[GLB_W-1];
        rd_glb_val   = glb_rdata[VALUE_W-1:0];

        hit        = in_frame_reg && (rd_stamp == epoch_reg);
        lookup_val = hit ? rd_slot_val : (rd_glb_valid ? rd_glb_val : '0);
        base_val   = hit ? rd_slot_val : rd_glb_val;
        use_base   = (mode_reg != MODE_STORE) && (hit || rd_glb_valid);
        result     = (mode_reg == MODE_LOAD) ? lookup_val
                   : (use_base ? sat_add(base_val, addend_reg) : addend_reg);
    end

    // Memory access control: clearing pass, request reads, target write-back
    always_comb begin
        mem_re     = accept || (state_reg == ST_SRC);
        slot_raddr = (state_reg == ST_SRC) ? tgt_slot_reg
                   : ((s_mode == MODE_ADDV) ? src_slot_in : tgt_slot_in);
        glb_raddr  = (state_reg == ST_SRC) ? tgt_glb_reg
                   : GA_W'((s_mode == MODE_ADDV) ? s_source_index : s_target_index);

        slot_we    = 1'b0;
        glb_we     = 1'b0;
        slot_waddr = tgt_slot_reg;
        glb_waddr  = tgt_glb_reg;
        slot_wdata = {epoch_reg, result};
        glb_wdata  = {1'b1, result};

        if (state_reg == ST_CLEAR) begin
            slot_we    = 1'b1;
            slot_waddr = clr_cnt_reg;
            slot_wdata = '0;
            glb_we     = ((SA_W + 1)'(clr_cnt_reg) < (SA_W + 1)'(MAX_SYMBOLS));
            glb_waddr  = GA_W'(clr_cnt_reg);
            glb_wdata  = '0;
        end else if (state_reg == ST_UPD && mode_reg != MODE_LOAD) begin
            if (in_frame_reg && (hit || !rd_glb_valid)) begin
                slot_we = 1'b1;
            end else begin
                glb_we = 1'b1;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        addend_next  = addend_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + SA_W'(1);
                if (clr_cnt_reg == SA_W'(SLOT_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    addend_next = s_operand_value;
                    if (!req_err) begin
                        state_next = (s_mode == MODE_ADDV) ? ST_SRC : ST_UPD;
                    end
                end
            end
            ST_SRC: begin
                // source lookup returns while the target read is issued
                addend_next = lookup_val;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_err_next   = m_err_reg;
        if (accept && req_err) begin
            m_valid_next = 1'b1;
            m_value_next = '0;
            m_err_next   = 1'b1;
        end else if (state_reg == ST_UPD) begin
            m_valid_next = 1'b1;
            m_value_next = result;
            m_err_next   = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            sym_reg     <= SYMBOLS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                sym_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addend_reg  <= addend_next;
        m_value_reg <= m_value_next;
        m_err_reg   <= m_err_next;
        if (accept) begin
            mode_reg     <= s_mode;
            in_frame_reg <= in_frame_in;
            epoch_reg    <= epoch_in;
            tgt_slot_reg <= tgt_slot_in;
            tgt_glb_reg  <= GA_W'(s_target_index);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_value_reg;
    assign m_index_error = m_err_reg;

    // Frame slots: {stamp, value}
    esvs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (mem_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Globals: {valid, value}
    esvs_ram #(
        .WIDTH (GLB_W),
        .DEPTH (MAX_SYMBOLS)
    ) u_glb_ram (
        .aclk  (aclk),
        .we    (glb_we),
        .waddr (glb_waddr),
        .wdata (glb_wdata),
        .re    (mem_re),
        .raddr (glb_raddr),
        .rdata (glb_rdata)
    );

endmodule

/* hw/rtl/esvs_checker.sv */
// esvs_checker: port-level checks on the variable store, bound to the top.
// Depends on esvs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module esvs_checker
    import esvs_pkg::*;
(
    input logic   aclk,
    input logic   aresetn,
    input logic   s_valid,
    input logic   s_ready,
    input logic   m_valid,
    input logic   m_ready,
    input value_t m_read_value,
    input logic   m_index_error
);

    // A stalled result holds
    `ESVS_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_value) && $stable(m_index_error))

    // Index errors always carry a zero value
    `ESVS_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && m_index_error, m_read_value == '0)

    // One request at a time: after an accept, no new request until the result can leave
    `ESVS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready || m_ready)

    // The clearing pass keeps requests out right after reset
    `ESVS_ASSERT_NOW(a_clear_blocks, aclk, aresetn, $rose(aresetn), !s_ready && !m_valid)

endmodule

bind epoch_scoped_variable_store_top esvs_checker u_esvs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_value  (m_read_value),
    .m_index_error (m_index_error)
);

/* sim/variable_store_checker.sv */
// variable_store_checker: watches the config, request and result channels of the
// epoch-scoped variable store, predicts every result and compares it in order.
// Depends on esvs_pkg for field widths, mode codes and value limits.
module variable_store_checker
    import esvs_pkg::*;
#(
    parameter int MAX_SYMBOLS = 64,
    parameter int MAX_FRAMES  = 16,
    parameter int EPOCH_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [INDEX_W-1:0]    s_target_index,
    input  logic [INDEX_W-1:0]    s_source_index,
    input  value_t                s_operand_value,
    input  logic [DEPTH_W-1:0]    s_frame_depth,
    input  logic [EPOCH_IN_W-1:0] s_frame_epoch,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  value_t                m_read_value,
    input  logic                  m_index_error,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_checked,
    output int                    flagged_errors,
    output int                    clamped_adds
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT = MAX_FRAMES * MAX_SYMBOLS;

    typedef struct packed {
        value_t value;
        logic   index_error;
    } outcome_t;

    // Shadow copy of the store and its one register
    logic [EPOCH_BITS-1:0] stamp_mem  [SLOT_COUNT];
    value_t                slot_mem   [SLOT_COUNT];
    logic                  global_set [MAX_SYMBOLS];
    value_t                global_mem [MAX_SYMBOLS];
    logic [CFG_W-1:0]      symbol_limit;

    outcome_t expected_results[$];
    int fail_total;
    int checked_total;
    int flag_total;
    int clamp_total;

    // 65-bit sum, then clamp to the signed 64-bit range
    function automatic value_t clamped_sum(input value_t a, input value_t b);
        logic signed [VALUE_W:0] wide;
        wide = $signed({a[VALUE_W-1], a}) + $signed({b[VALUE_W-1], b});
        if (wide[VALUE_W] != wide[VALUE_W-1]) begin
            clamp_total++;
            return wide[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        end
        return wide[VALUE_W-1:0];
    endfunction

    function automatic logic index_valid(input logic [INDEX_W-1:0] idx);
        return (idx < symbol_limit) && (idx < MAX_SYMBOLS);
    endfunction

    // Live frame slot first, then the global, else zero
    function automatic value_t visible_value(input logic scoped, input int base,
                                             input logic [EPOCH_BITS-1:0] epoch,
                                             input logic [INDEX_W-1:0] idx);
        if (scoped && stamp_mem[base + idx] == epoch) begin
            return slot_mem[base + idx];
        end
        return global_set[idx] ? global_mem[idx] : '0;
    endfunction

    // Applies one request to the shadow store and returns its result
    function automatic outcome_t apply_variable_op(input logic [MODE_W-1:0] mode,
                                                   input logic [INDEX_W-1:0] tgt,
                                                   input logic [INDEX_W-1:0] src,
                                                   input value_t operand,
                                                   input logic [DEPTH_W-1:0] depth_in,
                                                   input logic [EPOCH_IN_W-1:0] epoch_in);
        outcome_t              o;
        logic [EPOCH_BITS-1:0] epoch;
        logic                  scoped;
        int                    depth;
        int                    base;
        int                    slot;
        value_t                addend;
        o.value       = '0;
        o.index_error = 1'b0;
        epoch         = epoch_in[EPOCH_BITS-1:0];
        if (!index_valid(tgt) || (mode == MODE_ADDV && !index_valid(src))) begin
            o.index_error = 1'b1;
            return o;
        end
        depth  = (depth_in > MAX_FRAMES) ? MAX_FRAMES : int'(depth_in);
        scoped = (depth > 0) && (epoch != '0);
        base   = scoped ? (depth - 1) * MAX_SYMBOLS : 0;
        if (mode == MODE_LOAD) begin
            o.value = visible_value(scoped, base, epoch, tgt);
            return o;
        end
        addend = (mode == MODE_ADDV) ? visible_value(scoped, base, epoch, src) : operand;
        slot   = base + tgt;
        if (scoped) begin
            if (stamp_mem[slot] == epoch) begin
                o.value = (mode == MODE_STORE) ? addend : clamped_sum(slot_mem[slot], addend);
                slot_mem[slot] = o.value;
            end else if (global_set[tgt]) begin
                o.value = (mode == MODE_STORE) ? addend : clamped_sum(global_mem[tgt], addend);
                global_mem[tgt] = o.value;
            end else begin
                // first write in this frame creates the slot
                o.value         = addend;
                stamp_mem[slot] = epoch;
                slot_mem[slot]  = addend;
            end
        end else begin
            o.value = (mode == MODE_STORE || !global_set[tgt]) ? addend
                                                               : clamped_sum(global_mem[tgt], addend);
            global_set[tgt] = 1'b1;
            global_mem[tgt] = o.value;
        end
        return o;
    endfunction

    // Track handshakes at each edge; counters are published with nonblocking writes
    always @(posedge aclk) begin : track
        outcome_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                stamp_mem[i] = '0;
            end
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                global_set[i] = 1'b0;
            end
            symbol_limit = SYMBOLS_RESET;
            expected_results.delete();
            fail_total    = 0;
            checked_total = 0;
            flag_total    = 0;
            clamp_total   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                symbol_limit = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value=%h index_error=%b",
                             $time, m_read_value, m_index_error);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    checked_total++;
                    if (m_read_value !== want.value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.value, m_read_value);
                        fail_total++;
                    end
                    if (m_index_error !== want.index_error) begin
                        $display("%0t: index_error expected %b actual %b",
                                 $time, want.index_error, m_index_error);
                        fail_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = apply_variable_op(s_mode, s_target_index, s_source_index,
                                         s_operand_value, s_frame_depth, s_frame_epoch);
                if (want.index_error) begin
                    flag_total++;
                end
                expected_results.push_back(want);
            end
        end
        mismatches      <= fail_total;
        outstanding     <= expected_results.size();
        results_checked <= checked_total;
        flagged_errors  <= flag_total;
        clamped_adds    <= clamp_total;
    end

endmodule

/* sim/epoch_scoped_variable_store_top_tb.sv */
// epoch_scoped_variable_store_top_tb: clock, reset and request stimulus for the
// epoch-scoped variable store; checking is done by variable_store_checker.
// Depends on esvs_pkg, epoch_scoped_variable_store_top and variable_store_checker.
module epoch_scoped_variable_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import esvs_pkg::*;

    localparam int FRAME_LIMIT = 16;

    typedef struct {
        logic [MODE_W-1:0]     mode;
        logic [INDEX_W-1:0]    target;
        logic [INDEX_W-1:0]    source;
        value_t                operand;
        logic [DEPTH_W-1:0]    depth;
        logic [EPOCH_IN_W-1:0] epoch;
    } request_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data        = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode          = MODE_LOAD;
    logic [INDEX_W-1:0]    s_target_index  = '0;
    logic [INDEX_W-1:0]    s_source_index  = '0;
    value_t                s_operand_value = '0;
    logic [DEPTH_W-1:0]    s_frame_depth   = '0;
    logic [EPOCH_IN_W-1:0] s_frame_epoch   = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    value_t                m_read_value;
    logic                  m_index_error;

    int mismatches;
    int outstanding;
    int results_checked;
    int flagged_errors;
    int clamped_adds;

    // Interpreter call stack model used to shape requests
    int                    call_depth = 0;
    logic [EPOCH_IN_W-1:0] frame_epochs [FRAME_LIMIT + 1];
    bit                    send_calm  = 1'b0;
    bit                    recv_calm  = 1'b0;
    int                    sent_count = 0;
    request_t              directed[$];

    epoch_scoped_variable_store_top u_dut (.*);

    variable_store_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic request_t make_req(input logic [MODE_W-1:0] mode, input int target,
                                          input int source, input value_t operand,
                                          input int depth, input int epoch);
        request_t r;
        r.mode    = mode;
        r.target  = target[INDEX_W-1:0];
        r.source  = source[INDEX_W-1:0];
        r.operand = operand;
        r.depth   = depth[DEPTH_W-1:0];
        r.epoch   = epoch[EPOCH_IN_W-1:0];
        return r;
    endfunction

    // Mostly a small working set of variables so scopes collide
    function automatic logic [INDEX_W-1:0] pick_index();
        return ($urandom_range(9, 0) < 7) ? INDEX_W'($urandom_range(7, 0))
                                          : INDEX_W'($urandom_range(63, 0));
    endfunction

    function automatic value_t pick_operand();
        value_t v;
        case ($urandom_range(7, 0))
            0: v = VALUE_MAX - value_t'($urandom_range(3, 0));
            1: v = VALUE_MIN + value_t'($urandom_range(3, 0));
            2, 3: begin
                v = value_t'($urandom_range(255, 0)) <<< 28;
                if ($urandom_range(1, 0)) begin
                    v = -v;
                end
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Calls and returns move the frame stack; a few requests stray off it
    function automatic request_t random_request();
        request_t r;
        int       roll;
        roll = $urandom_range(99, 0);
        if (roll < 6 && call_depth < FRAME_LIMIT) begin
            call_depth++;
            case ($urandom_range(3, 0))
                0:       ; // same epoch again revives the old frame contents
                1:       frame_epochs[call_depth] = frame_epochs[call_depth] + 1'b1;
                default: frame_epochs[call_depth] = EPOCH_IN_W'($urandom_range(65535, 1));
            endcase
            if (frame_epochs[call_depth] == '0) begin
                frame_epochs[call_depth] = 1;
            end
        end else if (roll < 12 && call_depth > 0) begin
            call_depth--;
        end
        r.mode    = MODE_W'($urandom_range(3, 0));
        r.target  = pick_index();
        r.source  = pick_index();
        r.operand = pick_operand();
        r.depth   = DEPTH_W'(call_depth);
        r.epoch   = frame_epochs[call_depth];
        roll = $urandom_range(99, 0);
        if (roll < 8) begin
            r.depth = DEPTH_W'($urandom_range(31, 0));
        end else if (roll < 12) begin
            r.epoch = '0;
        end else if (roll < 16) begin
            r.epoch = EPOCH_IN_W'($urandom_range(65535, 0));
        end
        return r;
    endfunction

    // Drive one request and hold it until accepted
    task automatic send_request(input request_t r);
        int gap;
        gap = send_calm ? 0 : $urandom_range(13, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= r.mode;
        s_target_index  <= r.target;
        s_source_index  <= r.source;
        s_operand_value <= r.operand;
        s_frame_depth   <= r.depth;
        s_frame_epoch   <= r.epoch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        if (sent_count % 48 == 0) begin
            send_calm = ($urandom_range(3, 0) == 0);
        end
    endtask

    // Stop sending until every outstanding result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_symbols(input logic [CFG_W-1:0] limit);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            send_request(random_request());
            if ($urandom_range(149, 0) == 0) begin
                wait_drained();
            end
        end
    endtask

    // Result side: random stalls per result, with calm stretches
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        forever begin
            stall = recv_calm ? 0 : $urandom_range(13, 0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
            if (taken % 40 == 0) begin
                recv_calm = ($urandom_range(3, 0) == 0);
            end
        end
    end

    initial begin : stimulus
        for (int i = 0; i <= FRAME_LIMIT; i++) begin
            frame_epochs[i] = EPOCH_IN_W'($urandom_range(65535, 1));
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: globals, saturation, frame slots, epoch raise, deep and epoch-zero scopes
        directed.push_back(make_req(MODE_LOAD,  0,  0, '0, 0, 1));
        directed.push_back(make_req(MODE_STORE, 0,  0, VALUE_MAX, 0, 1));
        directed.push_back(make_req(MODE_DELTA, 0,  0, 64'sd1, 0, 1));
        directed.push_back(make_req(MODE_STORE, 1,  0, VALUE_MIN, 0, 1));
        directed.push_back(make_req(MODE_DELTA, 1,  0, -64'sd1, 0, 1));
        directed.push_back(make_req(MODE_ADDV,  1,  1, '0, 0, 1));
        directed.push_back(make_req(MODE_LOAD,  0,  0, '0, 3, 5));
        directed.push_back(make_req(MODE_STORE, 2,  0, 64'sh0000_0003_8000_0000, 3, 5));
        directed.push_back(make_req(MODE_LOAD,  2,  0, '0, 3, 5));
        directed.push_back(make_req(MODE_LOAD,  2,  0, '0, 3, 6));
        directed.push_back(make_req(MODE_STORE, 0,  0, 64'sd5 <<< 32, 3, 5));
        directed.push_back(make_req(MODE_ADDV,  2,  0, '0, 3, 5));
        directed.push_back(make_req(MODE_ADDV,  3,  2, '0, 3, 5));
        directed.push_back(make_req(MODE_DELTA, 7,  0, -(64'sd1 <<< 32), 3, 5));
        directed.push_back(make_req(MODE_STORE, 4,  0, -64'sd7, 31, 7));
        directed.push_back(make_req(MODE_LOAD,  4,  0, '0, 16, 7));
        directed.push_back(make_req(MODE_STORE, 5,  0, 64'sd42, 4, 0));
        directed.push_back(make_req(MODE_LOAD,  5,  0, '0, 4, 9));
        directed.push_back(make_req(MODE_STORE, 63, 0, -64'sd1, 16, 65535));
        directed.push_back(make_req(MODE_ADDV,  63, 63, '0, 16, 65535));
        directed.push_back(make_req(MODE_DELTA, 6,  0, VALUE_MIN, 0, 1));
        directed.push_back(make_req(MODE_ADDV,  62, 63, '0, 0, 1));
        directed.push_back(make_req(MODE_LOAD,  63, 0, '0, 1, 65535));
        foreach (directed[i]) begin
            send_request(directed[i]);
        end

        write_symbols(7'd127);
        run_random(420);

        // Limit of ten: target and source range errors, source ignored outside add-variable
        write_symbols(7'd10);
        directed.delete();
        directed.push_back(make_req(MODE_STORE, 10, 0,  64'sd1, 0, 1));
        directed.push_back(make_req(MODE_ADDV,  3,  12, '0, 0, 1));
        directed.push_back(make_req(MODE_LOAD,  9,  0,  '0, 0, 1));
        directed.push_back(make_req(MODE_LOAD,  10, 40, '0, 0, 1));
        directed.push_back(make_req(MODE_LOAD,  2,  40, '0, 0, 1));
        directed.push_back(make_req(MODE_DELTA, 9,  0,  VALUE_MAX, 2, 3));
        foreach (directed[i]) begin
            send_request(directed[i]);
        end
        run_random(300);

        write_symbols(7'd0);
        run_random(40);
        write_symbols(7'd1);
        run_random(80);
        write_symbols(CFG_W'($urandom_range(63, 2)));
        run_random(300);
        write_symbols(7'd64);
        run_random(440);

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Sent %0d requests over symbol limits 64, 127, 10, 0, 1, random and 64.",
                 sent_count);
        $display("%0d results checked, %0d flagged out of range, %0d adds clamped.",
                 results_checked, flagged_errors, clamped_adds);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[epoch_scoped_variable_store_top] OK");
        end else begin
            $display("[epoch_scoped_variable_store_top] ERROR");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("[epoch_scoped_variable_store_top] ERROR");
        $finish;
    end

endmodule

/* epoch_scoped_variable_store_top.f */
+incdir+hw/rtl
hw/rtl/esvs_pkg.sv
hw/rtl/esvs_ram.sv
hw/rtl/epoch_scoped_variable_store_top.sv
hw/rtl/esvs_checker.sv
sim/variable_store_checker.sv
sim/epoch_scoped_variable_store_top_tb.sv
